// File: hw/rtl/snapshot_stream_unpacker_defines.svh
// assertion macros for the snapshot stream unpacker
// used by the checker module, no other dependencies
`ifndef SNAPSHOT_STREAM_UNPACKER_DEFINES_SVH
`define SNAPSHOT_STREAM_UNPACKER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ssu_pkg.sv
// shared types, codes and constants of the snapshot stream unpacker
// no dependencies
`default_nettype none

package ssu_pkg;

    localparam int PAGE_BYTES_DEF = 16384;
    localparam int MAX_PAGES_DEF  = 12;
    localparam int QDEPTH         = 4;

    localparam logic [7:0]  BYTE_ED  = 8'hED;
    localparam logic [15:0] LEN_RAW  = 16'hFFFF;
    localparam logic [3:0]  PAGE_V1A = 4'd8;
    localparam logic [3:0]  PAGE_V1B = 4'd4;
    localparam logic [3:0]  PAGE_V1C = 4'd5;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_INFO  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_FORMAT   = 3'd1;
    localparam logic [2:0] ERR_PAGE     = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW = 3'd3;
    localparam logic [2:0] ERR_PACKED   = 3'd4;
    localparam logic [2:0] ERR_TRUNC    = 3'd5;

    typedef enum logic [2:0] {
        PH_HEADER, PH_V1DATA, PH_BLEN_LO, PH_BLEN_HI,
        PH_BPAGE, PH_BRAW, PH_BPACK, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ESC_NONE, ESC_ONE, ESC_TWO, ESC_COUNT
    } t_esc;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  page_number;
        logic [13:0] page_offset;
        logic [7:0]  fill_value;
        logic [7:0]  run_length;
        logic [1:0]  format_version;
        logic        is_packed;
        logic [1:0]  machine_class;
        logic [7:0]  hardware_code;
        logic [2:0]  error_code;
    } t_result;

    function automatic logic [1:0] class_of(input logic [1:0] ver, input logic [7:0] hw);
        logic [1:0] c;
        c = 2'd3;
        if (hw == 8'd0 || hw == 8'd1) begin
            c = 2'd0;
        end else if (hw == 8'd2) begin
            c = 2'd2;
        end else if (ver == 2'd2) begin
            if (hw == 8'd3 || hw == 8'd4) c = 2'd1;
        end else begin
            if (hw == 8'd3) c = 2'd0;
            else if (hw >= 8'd4 && hw <= 8'd6) c = 2'd1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/snapshot_stream_unpacker.sv
// snapshot stream unpacker: file bytes in, memory run writes, header info and errors out
//
// input channel: one file byte with its end flag is taken when push is high and full
// is low. bytes may follow each other in every cycle.
// result channel: while empty is low the oldest result is on o_result; pop takes it.
// each byte gives zero or one result. a result reaches the queue in the cycle after
// its byte is taken. the sustained rate is one byte per cycle while full is low;
// a four-entry result queue lets the receiver stall for up to four results before
// full rises and the input stalls too.
// the last byte of a file (end flag set) returns the parser to the header state,
// so the next byte starts a new file.
// reset clears the parser and empties the queue; no clearing pass is needed.
// PAGE_BYTES sets the page size, MAX_PAGES the first page number that is refused.
// depends on ssu_pkg, ssu_front, ssu_queue
`default_nettype none

module snapshot_stream_unpacker #(
    parameter int PAGE_BYTES = ssu_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = ssu_pkg::MAX_PAGES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire ssu_pkg::t_in_item i_item,
    input  wire logic              pop,
    output logic                   empty,
    output ssu_pkg::t_result       o_result
);
    import ssu_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;

    assign accept = push && !full;

    ssu_front #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_PAGES  (MAX_PAGES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_valid  (res_valid),
        .o_result (res)
    );

    ssu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_data  (res),
        .o_full  (full),
        .i_rd    (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

endmodule

`default_nettype wire

// File: hw/rtl/ssu_front.sv
// front end: parses file bytes and classifies each into at most one result
// depends on ssu_pkg
`default_nettype none

module ssu_front #(
    parameter int PAGE_BYTES = ssu_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = ssu_pkg::MAX_PAGES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire ssu_pkg::t_in_item i_item,
    output logic                  o_valid,
    output ssu_pkg::t_result      o_result
);
    import ssu_pkg::*;

    localparam int OW = $clog2(PAGE_BYTES) + 1;
    localparam int BW = (OW > 16) ? OW : 16;
    localparam int SW = ((OW > 8) ? OW : 8) + 1;

    t_phase r_phase, n_phase;
    t_esc   r_esc, n_esc;
    logic [7:0]    r_pos, n_pos;
    logic [1:0]    r_ver, n_ver;
    logic [6:0]    r_hl, n_hl;
    logic [7:0]    r_pc, n_pc;
    logic [BW-1:0] r_rem, n_rem;
    logic [3:0]    r_page, n_page;
    logic [OW-1:0] r_off, n_off;
    logic [7:0]    r_cnt, n_cnt;
    logic          r_packed, n_packed;

    logic [7:0] b;
    logic       eof;
    logic       fmt_ok, err1, err4, page_err, lit_now, run_now, lit_err, run_err, err3;
    logic [6:0] hl_eff;
    logic       have;

    assign b   = i_item.file_byte;
    assign eof = i_item.end_of_file;

    assign fmt_ok   = (b == 8'd23) || (b == 8'd54) || (b == 8'd55);
    assign err1     = (r_phase == PH_HEADER) && (r_ver != 2'd1) && (r_pos == 8'd30) && !fmt_ok;
    assign err4     = (r_phase == PH_HEADER) && (r_ver == 2'd1) && (r_pos == 8'd29) && r_packed;
    assign page_err = (r_phase == PH_BPAGE) && ({1'b0, b} >= 9'(MAX_PAGES));
    assign lit_now  = (r_phase == PH_BRAW) || ((r_phase == PH_BPACK) &&
                      ((r_esc == ESC_NONE) || ((r_esc == ESC_ONE) && (b != BYTE_ED))));
    assign run_now  = (r_phase == PH_BPACK) && (r_esc == ESC_COUNT) && (r_cnt != 8'd0);
    assign lit_err  = r_off >= OW'(PAGE_BYTES);
    assign run_err  = (SW'(r_off) + SW'(r_cnt)) > SW'(PAGE_BYTES);
    assign err3     = (lit_now && lit_err) || (run_now && run_err);

    // v2 and v3 header length follows from the extra length byte
    always_comb begin
        hl_eff = r_hl;
        if (r_pos == 8'd30) begin
            if (b == 8'd23) hl_eff = 7'd55;
            else            hl_eff = 7'(8'd32 + b);
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_esc    = r_esc;
        n_pos    = r_pos;
        n_ver    = r_ver;
        n_hl     = r_hl;
        n_pc     = r_pc;
        n_rem    = r_rem;
        n_page   = r_page;
        n_off    = r_off;
        n_cnt    = r_cnt;
        n_packed = r_packed;
        unique case (r_phase)
            PH_HEADER: begin
                if (r_pos == 8'd6) n_pc = b;
                if (r_pos == 8'd7) n_ver = ((r_pc | b) != 8'd0) ? 2'd1 : 2'd0;
                if (r_pos < 8'd255) n_pos = r_pos + 8'd1;
                if (r_ver == 2'd1) begin
                    if (r_pos == 8'd12) n_packed = (b != 8'd255) && b[4];
                    if (r_pos == 8'd29) begin
                        if (r_packed) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_V1DATA;
                            n_page  = PAGE_V1A;
                            n_off   = '0;
                        end
                    end
                end else if (r_pos >= 8'd30) begin
                    if (r_pos == 8'd30) begin
                        n_ver = (b == 8'd23) ? 2'd2 : 2'd3;
                        n_hl  = hl_eff;
                    end
                    if (err1) begin
                        n_phase = PH_DONE;
                    end else if (({1'b0, r_pos} + 9'd1) >= {2'b00, hl_eff}) begin
                        n_phase = PH_BLEN_LO;
                    end
                end
            end
            PH_V1DATA: begin
                n_off = r_off + OW'(1);
                if ((r_off + OW'(1)) >= OW'(PAGE_BYTES)) begin
                    n_off = '0;
                    if (r_page == PAGE_V1A)      n_page = PAGE_V1B;
                    else if (r_page == PAGE_V1B) n_page = PAGE_V1C;
                    else                         n_phase = PH_DONE;
                end
            end
            PH_BLEN_LO: begin
                n_rem   = BW'(b);
                n_phase = PH_BLEN_HI;
            end
            PH_BLEN_HI: begin
                n_rem   = BW'({b, r_rem[7:0]});
                n_phase = PH_BPAGE;
            end
            PH_BPAGE: begin
                if (page_err) begin
                    n_phase = PH_DONE;
                end else begin
                    n_page = b[3:0];
                    n_off  = '0;
                    n_esc  = ESC_NONE;
                    if (r_rem[15:0] == LEN_RAW) begin
                        n_rem   = BW'(PAGE_BYTES);
                        n_phase = PH_BRAW;
                    end else if (r_rem == '0) begin
                        n_phase = PH_BLEN_LO;
                    end else begin
                        n_phase = PH_BPACK;
                    end
                end
            end
            PH_BRAW: begin
                if (lit_err) begin
                    n_phase = PH_DONE;
                end else begin
                    n_off = r_off + OW'(1);
                    n_rem = r_rem - BW'(1);
                    if (r_rem == BW'(1)) n_phase = PH_BLEN_LO;
                end
            end
            PH_BPACK: begin
                unique case (r_esc)
                    ESC_NONE: begin
                        if (b == BYTE_ED) n_esc = ESC_ONE;
                        n_off = r_off + OW'(1);
                    end
                    ESC_ONE: begin
                        if (b == BYTE_ED) begin
                            // second escape byte takes back the provisional literal
                            n_esc = ESC_TWO;
                            if (r_off != '0) n_off = r_off - OW'(1);
                        end else begin
                            n_esc = ESC_NONE;
                            n_off = r_off + OW'(1);
                        end
                    end
                    ESC_TWO: begin
                        n_cnt = b;
                        n_esc = ESC_COUNT;
                    end
                    ESC_COUNT: begin
                        n_esc = ESC_NONE;
                        if (r_cnt != 8'd0) n_off = r_off + OW'(r_cnt);
                    end
                    default: n_esc = ESC_NONE;
                endcase
                if (err3) begin
                    n_phase = PH_DONE;
                end else begin
                    n_rem = r_rem - BW'(1);
                    if (r_rem == BW'(1)) begin
                        n_esc   = ESC_NONE;
                        n_phase = PH_BLEN_LO;
                    end
                end
            end
            PH_DONE: ;
            default: n_phase = PH_DONE;
        endcase
    end

    always_comb begin
        have     = 1'b0;
        o_result = '0;
        if (eof && n_phase != PH_BLEN_LO && n_phase != PH_DONE) begin
            have                 = 1'b1;
            o_result.result_kind = KIND_ERROR;
            o_result.error_code  = ERR_TRUNC;
        end else if (err1 || err4 || page_err || err3) begin
            have                 = 1'b1;
            o_result.result_kind = KIND_ERROR;
            o_result.error_code  = err1 ? ERR_FORMAT : err4 ? ERR_PACKED :
                                   page_err ? ERR_PAGE : ERR_OVERFLOW;
        end else if (r_phase == PH_HEADER) begin
            if (r_ver == 2'd1 && r_pos == 8'd12) begin
                have                    = 1'b1;
                o_result.result_kind    = KIND_INFO;
                o_result.format_version = 2'd1;
                o_result.is_packed      = (b != 8'd255) && b[4];
            end else if (r_ver != 2'd1 && r_pos == 8'd34) begin
                have                    = 1'b1;
                o_result.result_kind    = KIND_INFO;
                o_result.format_version = r_ver;
                o_result.machine_class  = class_of(r_ver, b);
                o_result.hardware_code  = b;
            end
        end else if (r_phase == PH_V1DATA || lit_now || run_now) begin
            have                 = 1'b1;
            o_result.result_kind = KIND_WRITE;
            o_result.page_number = r_page;
            o_result.page_offset = 14'(r_off);
            o_result.fill_value  = b;
            o_result.run_length  = run_now ? r_cnt : 8'd1;
        end
    end

    assign o_valid = i_accept && have;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && eof)) begin
            r_phase  <= PH_HEADER;
            r_esc    <= ESC_NONE;
            r_pos    <= '0;
            r_ver    <= '0;
            r_hl     <= 7'd30;
            r_pc     <= '0;
            r_rem    <= '0;
            r_page   <= '0;
            r_off    <= '0;
            r_cnt    <= '0;
            r_packed <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_esc    <= n_esc;
            r_pos    <= n_pos;
            r_ver    <= n_ver;
            r_hl     <= n_hl;
            r_pc     <= n_pc;
            r_rem    <= n_rem;
            r_page   <= n_page;
            r_off    <= n_off;
            r_cnt    <= n_cnt;
            r_packed <= n_packed;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ssu_queue.sv
// back end: short result queue between the parser and the result port
// depends on ssu_pkg
`default_nettype none

module ssu_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire ssu_pkg::t_result i_data,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic                  o_empty,
    output ssu_pkg::t_result      o_data
);
    import ssu_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    t_result          r_mem [QDEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt, n_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == (AW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (do_wr && !do_rd) n_cnt = r_cnt + (AW+1)'(1);
        if (do_rd && !do_wr) n_cnt = r_cnt - (AW+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) r_wp <= r_wp + AW'(1);
            if (do_rd) r_rp <= r_rp + AW'(1);
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ssu_checker.sv
// port checks for the snapshot stream unpacker, bound to the top level
// depends on ssu_pkg and snapshot_stream_unpacker_defines.svh
`default_nettype none
`include "snapshot_stream_unpacker_defines.svh"

module ssu_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              push,
    input wire logic              full,
    input wire ssu_pkg::t_in_item i_item,
    input wire logic              pop,
    input wire logic              empty,
    input wire ssu_pkg::t_result  o_result
);
    import ssu_pkg::*;

    `SSU_ASSERT_NOW(a_kind_known, i_clk, i_rst_n, !empty, o_result.result_kind != 2'd3, "bad result kind")
    `SSU_ASSERT_NOW(a_run_nonzero, i_clk, i_rst_n, !empty && o_result.result_kind == KIND_WRITE, o_result.run_length != 8'd0, "empty run")
    `SSU_ASSERT_NOW(a_err_code, i_clk, i_rst_n, !empty && o_result.result_kind == KIND_ERROR, o_result.error_code != 3'd0, "error without code")
    `SSU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_result), "stalled result changed")

endmodule

bind snapshot_stream_unpacker ssu_checker u_ssu_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the snapshot stream unpacker
// builds whole snapshot files, predicts every result and checks the result queue
// depends on ssu_pkg and the snapshot_stream_unpacker rtl
`timescale 1ns / 100ps

module testbench;
    import ssu_pkg::*;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push = 1'b0;
    logic     pop = 1'b0;
    t_in_item i_item = '0;
    logic     full;
    logic     empty;
    t_result  o_result;

    snapshot_stream_unpacker dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .pop      (pop),
        .empty    (empty),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    t_in_item   byte_stream[$];
    t_result    expected_results[$];
    logic [7:0] file_buf[$];
    int         mismatches = 0;
    int         in_gap = 0;
    int         out_gap = 0;
    bit         calm = 1'b0;

    // parser state of the prediction
    t_phase     ph;
    t_esc       esc;
    int         pos, ver, hdr_len, pc_low, blk_left, cur_page, wr_off, run_count;
    bit         v1_packed;
    t_result    pr;
    bit         pr_have;

    task automatic clear_parser();
        ph = PH_HEADER; esc = ESC_NONE; pos = 0; ver = 0; hdr_len = 30; pc_low = 0;
        blk_left = 0; cur_page = 0; wr_off = 0; run_count = 0; v1_packed = 1'b0;
    endtask

    task automatic emit_write(input int page, input int off, input int val, input int len);
        pr = '0;
        pr.result_kind = KIND_WRITE;
        pr.page_number = page[3:0];
        pr.page_offset = off[13:0];
        pr.fill_value  = val[7:0];
        pr.run_length  = len[7:0];
        pr_have = 1'b1;
    endtask

    task automatic emit_error(input logic [2:0] code);
        pr = '0;
        pr.result_kind = KIND_ERROR;
        pr.error_code  = code;
        pr_have = 1'b1;
        ph = PH_DONE;
    endtask

    function automatic logic [1:0] machine_of(input int v, input int hw);
        logic [1:0] mc;
        mc = 2'd3;
        case (hw)
            0, 1: mc = 2'd0;
            2: mc = 2'd2;
            3: mc = (v == 2) ? 2'd1 : 2'd0;
            4: mc = 2'd1;
            5, 6: mc = (v == 2) ? 2'd3 : 2'd1;
            default: mc = 2'd3;
        endcase
        return mc;
    endfunction

    task automatic write_literal(input int b);
        if (wr_off >= PAGE_BYTES_DEF) begin
            emit_error(ERR_OVERFLOW);
        end else begin
            emit_write(cur_page, wr_off, b, 1);
            wr_off++;
        end
    endtask

    task automatic header_step(input int b);
        int  flag;
        bit  stop;
        stop = 1'b0;
        if (pos == 6) pc_low = b;
        if (pos == 7) ver = ((pc_low | b) != 0) ? 1 : 0;
        if (ver == 1) begin
            if (pos == 12) begin
                // a flag byte of 255 reads as 1
                flag = (b == 255) ? 1 : b;
                v1_packed = (flag & 8'h10) != 0;
                pr = '0;
                pr.result_kind = KIND_INFO;
                pr.format_version = 2'd1;
                pr.is_packed = v1_packed;
                pr_have = 1'b1;
            end
            if (pos == 29) begin
                if (v1_packed) begin
                    emit_error(ERR_PACKED);
                    stop = 1'b1;
                end else begin
                    ph = PH_V1DATA; cur_page = PAGE_V1A; wr_off = 0;
                end
            end
        end else if (pos >= 30) begin
            if (pos == 30) begin
                if (b == 23) begin
                    ver = 2; hdr_len = 55;
                end else if (b == 54 || b == 55) begin
                    ver = 3; hdr_len = 32 + b;
                end else begin
                    emit_error(ERR_FORMAT);
                    stop = 1'b1;
                end
            end
            if (!stop) begin
                if (pos == 34) begin
                    pr = '0;
                    pr.result_kind = KIND_INFO;
                    pr.format_version = ver[1:0];
                    pr.machine_class = machine_of(ver, b);
                    pr.hardware_code = b[7:0];
                    pr_have = 1'b1;
                end
                if (pos + 1 >= hdr_len) ph = PH_BLEN_LO;
            end
        end
        if (!stop && pos < 255) pos++;
    endtask

    task automatic packed_step(input int b);
        case (esc)
            ESC_NONE: begin
                if (b == BYTE_ED) esc = ESC_ONE;
                write_literal(b);
            end
            ESC_ONE: begin
                if (b == BYTE_ED) begin
                    // the provisional literal of the first ed is overwritten by the run
                    esc = ESC_TWO;
                    if (wr_off > 0) wr_off--;
                end else begin
                    esc = ESC_NONE;
                    write_literal(b);
                end
            end
            ESC_TWO: begin
                run_count = b; esc = ESC_COUNT;
            end
            default: begin
                esc = ESC_NONE;
                if (run_count != 0) begin
                    if (wr_off + run_count > PAGE_BYTES_DEF) begin
                        emit_error(ERR_OVERFLOW);
                    end else begin
                        emit_write(cur_page, wr_off, b, run_count);
                        wr_off += run_count;
                    end
                end
            end
        endcase
        if (ph == PH_BPACK) begin
            blk_left--;
            if (blk_left == 0) begin
                esc = ESC_NONE; ph = PH_BLEN_LO;
            end
        end
    endtask

    task automatic unpack_byte(input t_in_item it);
        int b;
        b = it.file_byte;
        pr_have = 1'b0;
        case (ph)
            PH_HEADER: header_step(b);
            PH_V1DATA: begin
                emit_write(cur_page, wr_off, b, 1);
                wr_off++;
                if (wr_off >= PAGE_BYTES_DEF) begin
                    wr_off = 0;
                    if (cur_page == PAGE_V1A) cur_page = PAGE_V1B;
                    else if (cur_page == PAGE_V1B) cur_page = PAGE_V1C;
                    else ph = PH_DONE;
                end
            end
            PH_BLEN_LO: begin
                blk_left = b; ph = PH_BLEN_HI;
            end
            PH_BLEN_HI: begin
                blk_left = blk_left | (b << 8); ph = PH_BPAGE;
            end
            PH_BPAGE: begin
                if (b >= MAX_PAGES_DEF) begin
                    emit_error(ERR_PAGE);
                end else begin
                    cur_page = b; wr_off = 0; esc = ESC_NONE;
                    if (blk_left == LEN_RAW) begin
                        blk_left = PAGE_BYTES_DEF; ph = PH_BRAW;
                    end else if (blk_left == 0) begin
                        ph = PH_BLEN_LO;
                    end else begin
                        ph = PH_BPACK;
                    end
                end
            end
            PH_BRAW: begin
                write_literal(b);
                if (ph == PH_BRAW) begin
                    blk_left--;
                    if (blk_left == 0) ph = PH_BLEN_LO;
                end
            end
            PH_BPACK: packed_step(b);
            default: ;
        endcase
        if (it.end_of_file) begin
            if (ph != PH_BLEN_LO && ph != PH_DONE) emit_error(ERR_TRUNC);
            clear_parser();
        end
        if (pr_have) expected_results.push_back(pr);
    endtask

    // ---------------- file building ----------------
    task automatic send_file(input int cut);
        t_in_item it;
        int n;
        n = (cut > 0 && cut < file_buf.size()) ? cut : file_buf.size();
        for (int i = 0; i < n; i++) begin
            it.file_byte = file_buf[i];
            it.end_of_file = (i == n - 1);
            byte_stream.push_back(it);
        end
        file_buf.delete();
    endtask

    task automatic add_v1_header(input logic [7:0] flag);
        logic [7:0] b;
        for (int p = 0; p < 30; p++) begin
            b = 8'($urandom);
            if (p == 6) b = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
            if (p == 7 && file_buf[6] == 8'd0) b = 8'($urandom_range(1, 255));
            if (p == 12) b = flag;
            file_buf.push_back(b);
        end
    endtask

    task automatic add_v23_header(input logic [7:0] len_code, input logic [7:0] hw);
        logic [7:0] b;
        int total;
        total = (len_code == 23) ? 55 : (len_code == 54 || len_code == 55) ? 32 + len_code : 31;
        for (int p = 0; p < total; p++) begin
            b = 8'($urandom);
            if (p == 6 || p == 7 || p == 31) b = 8'd0;
            if (p == 30) b = len_code;
            if (p == 34) b = hw;
            file_buf.push_back(b);
        end
    endtask

    task automatic add_block(input logic [7:0] page, input int pieces, input bit big_runs);
        logic [7:0] data[$];
        int k;
        for (int i = 0; i < pieces; i++) begin
            k = big_runs ? 2 : $urandom_range(0, 9);
            if (k < 4) begin
                data.push_back(8'($urandom_range(0, 236)));
            end else if (k == 4) begin
                // lone escape byte followed by a plain byte
                data.push_back(BYTE_ED);
                data.push_back(8'($urandom_range(0, 236)));
            end else begin
                data.push_back(BYTE_ED);
                data.push_back(BYTE_ED);
                data.push_back(big_runs ? 8'd255 :
                               ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom));
                data.push_back(8'($urandom));
            end
        end
        // sometimes leave an escape unfinished at the end of the block
        k = $urandom_range(0, 7);
        if (k == 0) data.push_back(BYTE_ED);
        if (k == 1) begin
            data.push_back(BYTE_ED); data.push_back(BYTE_ED);
        end
        if (k == 2) begin
            data.push_back(BYTE_ED); data.push_back(BYTE_ED); data.push_back(8'($urandom));
        end
        file_buf.push_back(8'(data.size() % 256));
        file_buf.push_back(8'(data.size() / 256));
        file_buf.push_back(page);
        foreach (data[i]) file_buf.push_back(data[i]);
    endtask

    function automatic logic [7:0] pick_hw();
        return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] pick_len_code();
        int r;
        r = $urandom_range(0, 2);
        return (r == 0) ? 8'd23 : (r == 1) ? 8'd54 : 8'd55;
    endfunction

    task automatic build_stimulus();
        int r, nblk;
        logic [7:0] seq[16];
        // short directed files
        add_v1_header(8'h10);
        file_buf.push_back(8'h00); file_buf.push_back(8'hFF);
        send_file(0);
        add_v23_header(8'd0, 8'd0);
        send_file(0);
        add_v1_header(8'hFF);
        file_buf.push_back(8'h00); file_buf.push_back(8'hFF);
        send_file(0);
        add_v23_header(8'd23, 8'd4);
        seq = '{8'h00, 8'h00, 8'd0, 8'h00, 8'hFF, BYTE_ED, 8'h05, BYTE_ED, BYTE_ED,
                8'h00, 8'h41, BYTE_ED, BYTE_ED, 8'hFF, 8'h00, BYTE_ED};
        foreach (seq[i]) file_buf.push_back(seq[i]);
        file_buf[55] = 8'd13;
        file_buf.push_back(8'h00); file_buf.push_back(8'h00); file_buf.push_back(8'd15);
        send_file(0);

        // random files, mostly well formed
        while (byte_stream.size() < 1500) begin
            r = $urandom_range(0, 99);
            if (r < 90) begin
                if (r < 80) add_v23_header(pick_len_code(), pick_hw());
                nblk = $urandom_range(0, 4);
                if (r >= 80) add_v1_header(8'($urandom));
                else for (int i = 0; i < nblk; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        file_buf.push_back(8'h00); file_buf.push_back(8'h00);
                        file_buf.push_back(8'($urandom_range(0, 11)));
                    end else begin
                        add_block(8'($urandom_range(0, 11)), $urandom_range(1, 12), 1'b0);
                    end
                end
                if (r >= 60 && r < 70) add_block(8'($urandom_range(12, 255)), 3, 1'b0);
                if (r >= 70 && r < 75) add_block(8'($urandom_range(0, 11)), 70, 1'b1);
                if (r >= 80) for (int i = 0; i < 20; i++) file_buf.push_back(8'($urandom));
                send_file(($urandom_range(0, 5) == 0) ? $urandom_range(1, file_buf.size()) : 0);
            end else begin
                for (int i = $urandom_range(1, 60); i > 0; i--)
                    file_buf.push_back(8'($urandom));
                send_file(0);
            end
        end

        // a short uncompressed v1 image and a raw page block, both cut by the file end
        add_v1_header(8'h00);
        for (int i = 0; i < 40; i++) file_buf.push_back(8'($urandom));
        send_file(0);
        add_v23_header(8'd54, 8'd5);
        file_buf.push_back(8'hFF); file_buf.push_back(8'hFF); file_buf.push_back(8'd11);
        for (int i = 0; i < 40; i++) file_buf.push_back(8'($urandom));
        send_file(0);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                unpack_byte(i_item);
                void'(byte_stream.pop_front());
                if ($urandom_range(0, 299) == 0) calm = !calm;
            end
            if (!(push && full)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    push <= 1'b0;
                end else if (byte_stream.size() > 0) begin
                    push <= 1'b1;
                    i_item <= byte_stream[0];
                    in_gap = gap_len();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", o_result);
                end else begin
                    e = expected_results.pop_front();
                    if (e.result_kind !== o_result.result_kind ||
                        e.page_number !== o_result.page_number ||
                        e.page_offset !== o_result.page_offset ||
                        e.fill_value !== o_result.fill_value ||
                        e.run_length !== o_result.run_length ||
                        e.format_version !== o_result.format_version ||
                        e.is_packed !== o_result.is_packed ||
                        e.machine_class !== o_result.machine_class ||
                        e.hardware_code !== o_result.hardware_code ||
                        e.error_code !== o_result.error_code) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", e, o_result);
                    end
                end
                out_gap = gap_len();
            end
            if (out_gap > 0) begin
                out_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        clear_parser();
        build_stimulus();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (byte_stream.size() == 0 && expected_results.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
